[hdl/lrukv_pkg.sv]
package lrukv_pkg;

    localparam int DEF_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CAP_W       = 5;
    localparam int CMP_W       = 8;

    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic load_req;
        logic match;
        logic promote;
        logic ram_rd;
        logic ram_wr;
        logic evict;
        logic insert;
        logic out_miss;
        logic out_hit;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic is_put;
        logic full;
        logic out_free;
    } t_dp_status;

endpackage

[hdl/lrukv_ram.sv]
module lrukv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/lrukv_datapath.sv]
module lrukv_datapath #(
    parameter int ENTRIES = lrukv_pkg::DEF_ENTRIES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lrukv_pkg::t_dp_cmd            i_cmd,
    output lrukv_pkg::t_dp_status         o_status,
    input  logic                          i_op,
    input  logic [lrukv_pkg::KEY_W-1:0]   i_key,
    input  logic [lrukv_pkg::VAL_W-1:0]   i_value,
    input  logic                          i_cfg_valid,
    input  logic [lrukv_pkg::CAP_W-1:0]   i_cfg_data,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic                          o_m_found,
    output logic [lrukv_pkg::VAL_W-1:0]   o_m_data
);

    import lrukv_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    logic             r_op;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    logic [CAP_W-1:0] r_cap;

    logic [ENTRIES-1:0] r_valid;
    logic [KEY_W-1:0]   r_keys [ENTRIES];
    logic [IW-1:0]      r_rank [ENTRIES];
    logic [CW-1:0]      r_count;

    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    logic [IW-1:0] r_hit_rank;

    logic             r_out_valid;
    logic             r_out_found;
    logic [VAL_W-1:0] r_out_data;

    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] victim_vec;
    logic [ENTRIES-1:0] free_vec;
    logic [ENTRIES-1:0] invalid_vec;
    logic [IW-1:0]      n_hit_idx;
    logic [IW-1:0]      n_hit_rank;
    logic [IW-1:0]      free_idx;
    logic [IW-1:0]      last_rank;
    logic [CMP_W-1:0]   limit;
    logic               full;
    logic               out_free;
    logic [VAL_W-1:0]   ram_rd_data;

    assign invalid_vec = ~r_valid;
    assign free_vec    = invalid_vec & (~invalid_vec + 1'b1);
    assign last_rank   = IW'(r_count - CW'(1));

    always_comb begin
        n_hit_idx  = '0;
        n_hit_rank = '0;
        free_idx   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match_vec[i]  = r_valid[i] && (r_keys[i] == r_key);
            victim_vec[i] = r_valid[i] && (r_rank[i] == last_rank);
            if (match_vec[i]) begin
                n_hit_idx  = n_hit_idx | IW'(i);
                n_hit_rank = n_hit_rank | r_rank[i];
            end
            if (free_vec[i]) begin
                free_idx = free_idx | IW'(i);
            end
        end
    end

    always_comb begin
        if (r_cap == '0) begin
            limit = CMP_W'(1);
        end else if (CMP_W'(r_cap) > CMP_W'(ENTRIES)) begin
            limit = CMP_W'(ENTRIES);
        end else begin
            limit = CMP_W'(r_cap);
        end
    end

    assign full     = CMP_W'(r_count) >= limit;
    assign out_free = !r_out_valid || i_m_tready;

    assign o_status.hit      = r_hit;
    assign o_status.is_put   = (r_op == OP_PUT);
    assign o_status.full     = full;
    assign o_status.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_op    <= i_op;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (i_cmd.match) begin
            r_hit      <= |match_vec;
            r_hit_idx  <= n_hit_idx;
            r_hit_rank <= n_hit_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (i_cmd.evict) begin
            r_valid <= r_valid & ~victim_vec;
            r_count <= r_count - CW'(1);
        end else if (i_cmd.insert) begin
            r_valid <= r_valid | free_vec;
            r_count <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_cmd.insert) begin
                if (free_vec[i]) begin
                    r_keys[i] <= r_key;
                    r_rank[i] <= '0;
                end else if (r_valid[i]) begin
                    r_rank[i] <= r_rank[i] + IW'(1);
                end
            end else if (i_cmd.promote) begin
                if (IW'(i) == r_hit_idx) begin
                    r_rank[i] <= '0;
                end else if (r_valid[i] && (r_rank[i] < r_hit_rank)) begin
                    r_rank[i] <= r_rank[i] + IW'(1);
                end
            end
        end
    end

    lrukv_ram #(
        .WIDTH(VAL_W),
        .DEPTH(ENTRIES)
    ) u_value_ram (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.ram_wr || i_cmd.insert),
        .i_wr_addr(i_cmd.insert ? free_idx : r_hit_idx),
        .i_wr_data(r_value),
        .i_rd_en  (i_cmd.ram_rd),
        .i_rd_addr(r_hit_idx),
        .o_rd_data(ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_hit || i_cmd.out_miss) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_hit) begin
            r_out_found <= 1'b1;
            r_out_data  <= ram_rd_data;
        end else if (i_cmd.out_miss) begin
            r_out_found <= 1'b0;
            r_out_data  <= MISS_VALUE;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_found  = r_out_found;
    assign o_m_data   = r_out_data;

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CW'($countones(r_valid)))
        else $error("Entry count disagrees with the valid bits.");

    a_unique_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(match_vec))
        else $error("More than one valid entry holds the same key.");

    a_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |-> (r_valid != '1))
        else $error("Insert issued with no free entry.");

    a_out_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_hit || i_cmd.out_miss) |-> out_free)
        else $error("Result loaded while the output register still holds an item.");

endmodule

[hdl/lrukv_ctrl.sv]
module lrukv_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  lrukv_pkg::t_dp_status i_status,
    output lrukv_pkg::t_dp_cmd    o_cmd
);

    import lrukv_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_ACT,
        S_READ,
        S_INSERT
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd n_cmd;

    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_cmd.load_req = 1'b1;
                    n_state        = S_MATCH;
                end
            end
            S_MATCH: begin
                n_cmd.match = 1'b1;
                n_state     = S_ACT;
            end
            S_ACT: begin
                priority if (!i_status.is_put && i_status.hit) begin
                    n_cmd.ram_rd  = 1'b1;
                    n_cmd.promote = 1'b1;
                    n_state       = S_READ;
                end else if (!i_status.is_put) begin
                    if (i_status.out_free) begin
                        n_cmd.out_miss = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else if (i_status.hit) begin
                    n_cmd.ram_wr  = 1'b1;
                    n_cmd.promote = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    n_cmd.evict = i_status.full;
                    n_state     = S_INSERT;
                end
            end
            S_READ: begin
                if (i_status.out_free) begin
                    n_cmd.out_hit = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_INSERT: begin
                n_cmd.insert = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_cmd      = n_cmd;

endmodule

[hdl/lru_key_value_cache.sv]
// Channel   Direction  Signals                               Contents
// s         in         i_s_tvalid, o_s_tready, i_s_tdata,    request: get or put
//                      i_s_tuser
// m         out        o_m_tvalid, i_m_tready, o_m_tdata,    get result
//                      o_m_tuser
// cfg       in         i_cfg_valid, o_cfg_ready, i_cfg_data  capacity limit
//
// A get or a put passes through the controller states in order: register the request,
// compare the key against every entry, then update the recency ranks and access the value
// RAM. A get that hits then passes through a read state to hand out the value, and a put
// of a new key passes through an insert state.
// Reset clears all valid bits and sets the capacity limit to 16; there is no clearing pass.
// A full output register holds the controller until the item is taken downstream.
module lru_key_value_cache #(
    parameter int ENTRIES = lrukv_pkg::DEF_ENTRIES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // key [31:0], value [63:32]
    input  logic [63:0]                 i_s_tdata,
    // operation [0]
    input  logic [0:0]                  i_s_tuser,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // read_value [31:0]
    output logic [31:0]                 o_m_tdata,
    // found [0]
    output logic [0:0]                  o_m_tuser,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lrukv_pkg::CAP_W-1:0] i_cfg_data
);

    import lrukv_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    lrukv_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    lrukv_datapath #(
        .ENTRIES(ENTRIES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_op       (i_s_tuser[0]),
        .i_key      (i_s_tdata[KEY_W-1:0]),
        .i_value    (i_s_tdata[KEY_W+VAL_W-1:KEY_W]),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_found  (o_m_tuser[0]),
        .o_m_data   (o_m_tdata)
    );

endmodule
